// File: design/strip_detector_calibration_macros.svh
// ----------------------------------------------------------------------------
// Strip detector calibration assertion macros
// Shared concurrent assertion forms for the calibration block.
// ----------------------------------------------------------------------------
`ifndef STRIP_DETECTOR_CALIBRATION_MACROS_SVH
`define STRIP_DETECTOR_CALIBRATION_MACROS_SVH

// same-cycle implication under reset
`define SDC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define SDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sdc_pkg.sv
// ----------------------------------------------------------------------------
// Strip detector calibration package
// Word layouts, constants and saturation helper shared by the block.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam int SIDE_W     = 2;
    localparam int INDEX_W    = 5;
    localparam int RAW_W      = 13;
    localparam int GAIN_W     = 18;
    localparam int OFFSET_W   = 24;
    localparam int THR_W      = 16;
    localparam int CAL_GAIN_W = 20;
    localparam int COUNT_W    = 6;
    localparam int SIDE_COUNT = 4;

    localparam logic [RAW_W-1:0]     ADC_LIMIT     = 13'd4096;
    localparam logic signed [14:0]   RAW_SENTINEL  = -15'sd9999;
    localparam logic signed [31:0]   VAL_SENTINEL  = -32'sd2559744;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = 6'd63;

    localparam logic [2:0] REG_HIT_THRESHOLD    = 3'd0;
    localparam logic [2:0] REG_CAL_GAIN_LEFT    = 3'd1;
    localparam logic [2:0] REG_CAL_OFFSET_LEFT  = 3'd2;
    localparam logic [2:0] REG_CAL_GAIN_RIGHT   = 3'd3;
    localparam logic [2:0] REG_CAL_OFFSET_RIGHT = 3'd4;

    localparam logic signed [THR_W-1:0]      RST_HIT_THRESHOLD    = 16'sd500;
    localparam logic signed [CAL_GAIN_W-1:0] RST_CAL_GAIN_LEFT    = 20'sd470416;
    localparam logic signed [OFFSET_W-1:0]   RST_CAL_OFFSET_LEFT  = -24'sd390206;
    localparam logic signed [CAL_GAIN_W-1:0] RST_CAL_GAIN_RIGHT   = 20'sd503663;
    localparam logic signed [OFFSET_W-1:0]   RST_CAL_OFFSET_RIGHT = -24'sd421446;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] coef_offset;
        logic signed [GAIN_W-1:0]   coef_gain;
        logic [RAW_W-1:0]           raw_adc;
        logic [INDEX_W-1:0]         strip_index;
        logic [SIDE_W-1:0]          strip_side;
    } sdc_in_t;

    typedef struct packed {
        logic                last;
        logic                sat;
        logic [SIDE_W-1:0]   side;
        logic [INDEX_W-1:0]  index;
        logic [RAW_W-1:0]    raw;
    } sdc_tag_t;

    typedef struct packed {
        logic signed [THR_W-1:0]      hit_threshold;
        logic signed [CAL_GAIN_W-1:0] gain_left;
        logic signed [OFFSET_W-1:0]   offset_left;
        logic signed [CAL_GAIN_W-1:0] gain_right;
        logic signed [OFFSET_W-1:0]   offset_right;
    } sdc_cal_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  hits_rb;
        logic [COUNT_W-1:0]  hits_rf;
        logic [COUNT_W-1:0]  hits_lb;
        logic [COUNT_W-1:0]  hits_lf;
        logic signed [31:0]  calibrated_value;
        logic signed [31:0]  stage_one_value;
        logic signed [14:0]  raw_echo;
        logic [INDEX_W-1:0]  index_out;
        logic [SIDE_W-1:0]   side_out;
    } sdc_out_t;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
        logic signed [31:0] r;
        if (x > 38'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -38'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// File: design/strip_detector_calibration.sv
// ----------------------------------------------------------------------------
// Strip detector calibration
// Two-stage per-strip and per-half gain/offset calibration with hit counts.
//
//  Channel   Dir  Handshake               Contents
//  s_axis    in   tvalid/tready           load or sample word, tuser = action
//  m_axis    out  tvalid/tready           calibrated strip word, tlast = event end
//  cfg       in   cfg_wr_en               threshold and side gain/offset registers
//
//  One word per cycle unless the output stalls; a sample is registered at the
//  coefficient RAM read at acceptance, then product, stage one, side gain, output.
//  A stalled output freezes the whole pipeline; s_axis_tready follows it.
//  Reset clears valids and hit counts, presets registers; tables need no clear.
// ----------------------------------------------------------------------------
module strip_detector_calibration
    import sdc_pkg::*;
#(
    parameter int SIDES  = 4,
    parameter int STRIPS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // strip_side, strip_index, raw_adc, coef_gain, coef_offset, zero fill
    input  logic [63:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    // action
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // side_out, index_out, raw_echo, stage_one_value, calibrated_value,
    // hits_lf, hits_lb, hits_rf, hits_rb, zero fill
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast,
    // adc_saturated
    output logic         m_axis_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    `include "strip_detector_calibration_macros.svh"

    sdc_cal_t cal_reg;
    sdc_in_t  in_word;
    logic     adv;
    logic     accept;

    logic               s1_valid;
    sdc_tag_t           s1_tag;
    logic signed [31:0] s1_value;
    sdc_out_t           out_word;
    logic               out_valid, out_last, out_sat, counts_clear;

    assign adv     = !out_valid || m_axis_tready;
    assign accept  = s_axis_tvalid && adv;
    assign in_word = sdc_in_t'(s_axis_tdata[61:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.hit_threshold <= RST_HIT_THRESHOLD;
            cal_reg.gain_left     <= RST_CAL_GAIN_LEFT;
            cal_reg.offset_left   <= RST_CAL_OFFSET_LEFT;
            cal_reg.gain_right    <= RST_CAL_GAIN_RIGHT;
            cal_reg.offset_right  <= RST_CAL_OFFSET_RIGHT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_HIT_THRESHOLD:    cal_reg.hit_threshold <= cfg_data[THR_W-1:0];
                REG_CAL_GAIN_LEFT:    cal_reg.gain_left     <= cfg_data[CAL_GAIN_W-1:0];
                REG_CAL_OFFSET_LEFT:  cal_reg.offset_left   <= cfg_data[OFFSET_W-1:0];
                REG_CAL_GAIN_RIGHT:   cal_reg.gain_right    <= cfg_data[CAL_GAIN_W-1:0];
                REG_CAL_OFFSET_RIGHT: cal_reg.offset_right  <= cfg_data[OFFSET_W-1:0];
                default:              ;
            endcase
        end
    end

    sdc_coef_stage #(.SIDES(SIDES), .STRIPS(STRIPS)) u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .accept   (accept),
        .action   (s_axis_tuser),
        .last     (s_axis_tlast),
        .in_word  (in_word),
        .s1_valid (s1_valid),
        .s1_tag   (s1_tag),
        .s1_value (s1_value)
    );

    sdc_gain_stage u_gain (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .cal          (cal_reg),
        .s1_valid     (s1_valid),
        .s1_tag       (s1_tag),
        .s1_value     (s1_value),
        .out_valid    (out_valid),
        .out_word     (out_word),
        .out_last     (out_last),
        .out_sat      (out_sat),
        .counts_clear (counts_clear)
    );

    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {2'b00, out_word};
    assign m_axis_tlast  = out_last;
    assign m_axis_tuser  = out_sat;

    `SDC_ASSERT_IMPLIES(a_counts_only_at_end, clk, rst_n,
        m_axis_tvalid && !m_axis_tlast,
        out_word.hits_lf == '0 && out_word.hits_lb == '0
            && out_word.hits_rf == '0 && out_word.hits_rb == '0,
        "hit counts shown outside event end")
    `SDC_ASSERT_IMPLIES(a_sat_sentinel, clk, rst_n,
        m_axis_tvalid && m_axis_tuser,
        out_word.raw_echo == RAW_SENTINEL && out_word.calibrated_value == VAL_SENTINEL
            && out_word.stage_one_value == VAL_SENTINEL,
        "saturated word without sentinel")
    `SDC_ASSERT_NEXT(a_end_emits, clk, rst_n,
        counts_clear,
        m_axis_tvalid && m_axis_tlast,
        "event end not presented after count clear")

endmodule

// File: design/sdc_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/sdc_coef_stage.sv
// ----------------------------------------------------------------------------
// Strip coefficient stage
// Holds the per-strip tables and computes the first stage value.
// ----------------------------------------------------------------------------
module sdc_coef_stage
    import sdc_pkg::*;
#(
    parameter int SIDES  = 4,
    parameter int STRIPS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               accept,
    input  logic               action,
    input  logic               last,
    input  sdc_in_t            in_word,
    output logic               s1_valid,
    output sdc_tag_t           s1_tag,
    output logic signed [31:0] s1_value
);

    localparam int DEPTH  = SIDES * STRIPS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [GAIN_W-1:0]   gain_q;
    logic [OFFSET_W-1:0] offset_q;

    logic               v1_reg, v2_reg, v3_reg;
    logic               in_range1_reg;
    sdc_tag_t           tag1_reg, tag2_reg, tag3_reg;
    logic signed [31:0] prod2_reg, prod2_next;
    logic signed [OFFSET_W-1:0] off2_reg, off2_next;
    logic signed [31:0] s1_reg, s1_next;
    logic signed [GAIN_W-1:0]   gain_sel;
    logic signed [RAW_W:0]      raw_s;
    logic signed [33:0]         sum;

    assign in_range = (32'(in_word.strip_side) < 32'(SIDES))
                   && (32'(in_word.strip_index) < 32'(STRIPS));
    assign addr = ADDR_W'(in_word.strip_side) * ADDR_W'(STRIPS)
                + ADDR_W'(in_word.strip_index);

    sdc_ram #(.WIDTH(GAIN_W), .DEPTH(DEPTH)) u_gain_ram (
        .clk   (clk),
        .we    (accept && !action && in_range),
        .waddr (addr),
        .wdata (in_word.coef_gain),
        .re    (accept && action),
        .raddr (addr),
        .rdata (gain_q)
    );

    sdc_ram #(.WIDTH(OFFSET_W), .DEPTH(DEPTH)) u_offset_ram (
        .clk   (clk),
        .we    (accept && !action && in_range),
        .waddr (addr),
        .wdata (in_word.coef_offset),
        .re    (accept && action),
        .raddr (addr),
        .rdata (offset_q)
    );

    always_comb
    begin
        gain_sel   = in_range1_reg ? $signed(gain_q) : '0;
        off2_next  = in_range1_reg ? $signed(offset_q) : '0;
        raw_s      = $signed({1'b0, tag1_reg.raw});
        prod2_next = gain_sel * raw_s;
        // round half up over six fraction bits
        sum = 34'((33'(prod2_reg) + 33'sd32) >>> 6) + 34'(off2_reg);
        s1_next = tag2_reg.sat ? VAL_SENTINEL : sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= accept && action;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_range1_reg <= in_range;
            tag1_reg      <= '{last:  last,
                               sat:   (in_word.raw_adc > ADC_LIMIT),
                               side:  in_word.strip_side,
                               index: in_word.strip_index,
                               raw:   in_word.raw_adc};
            tag2_reg      <= tag1_reg;
            prod2_reg     <= prod2_next;
            off2_reg      <= off2_next;
            tag3_reg      <= tag2_reg;
            s1_reg        <= s1_next;
        end
    end

    assign s1_valid = v3_reg;
    assign s1_tag   = tag3_reg;
    assign s1_value = s1_reg;

endmodule

// File: design/sdc_gain_stage.sv
// ----------------------------------------------------------------------------
// Side gain stage
// Applies the shared side gain and offset, counts hits and holds the result.
// ----------------------------------------------------------------------------
module sdc_gain_stage
    import sdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  sdc_cal_t           cal,
    input  logic               s1_valid,
    input  sdc_tag_t           s1_tag,
    input  logic signed [31:0] s1_value,
    output logic               out_valid,
    output sdc_out_t           out_word,
    output logic               out_last,
    output logic               out_sat,
    output logic               counts_clear
);

    logic               v4_reg;
    sdc_tag_t           tag4_reg;
    logic signed [31:0] s1_4_reg;
    logic signed [51:0] prod4_reg, prod4_next;
    logic signed [CAL_GAIN_W-1:0] gain_sel;
    logic signed [OFFSET_W-1:0]   off_sel;
    logic signed [37:0] c_wide;
    logic signed [31:0] c_val;
    logic signed [31:0] thr_q8;
    logic               hit;

    logic [COUNT_W-1:0] count_reg  [SIDE_COUNT];
    logic [COUNT_W-1:0] count_next [SIDE_COUNT];
    logic [COUNT_W-1:0] count_upd  [SIDE_COUNT];

    logic     out_valid_reg;
    sdc_out_t out_reg, out_next;
    logic     last_reg, sat_reg;

    always_comb
    begin
        gain_sel   = s1_tag.side[1] ? cal.gain_right : cal.gain_left;
        prod4_next = gain_sel * s1_value;

        off_sel = tag4_reg.side[1] ? cal.offset_right : cal.offset_left;
        // round half up over sixteen fraction bits
        c_wide  = 38'((prod4_reg + 52'sd32768) >>> 16) + 38'(off_sel);
        c_val   = tag4_reg.sat ? VAL_SENTINEL : sat32(c_wide);
        thr_q8  = {{8{cal.hit_threshold[THR_W-1]}}, cal.hit_threshold, 8'd0};
        hit     = c_val > thr_q8;

        for (int i = 0; i < SIDE_COUNT; i++)
        begin
            count_upd[i] = count_reg[i];
            if (hit && (32'(tag4_reg.side) == i) && (count_reg[i] < COUNT_MAX))
            begin
                count_upd[i] = count_reg[i] + 1'b1;
            end
            count_next[i] = tag4_reg.last ? '0 : count_upd[i];
        end

        out_next.side_out         = tag4_reg.side;
        out_next.index_out        = tag4_reg.index;
        out_next.raw_echo         = tag4_reg.sat ? RAW_SENTINEL
                                                 : $signed({2'b00, tag4_reg.raw});
        out_next.stage_one_value  = s1_4_reg;
        out_next.calibrated_value = c_val;
        out_next.hits_lf = tag4_reg.last ? count_upd[0] : '0;
        out_next.hits_lb = tag4_reg.last ? count_upd[1] : '0;
        out_next.hits_rf = tag4_reg.last ? count_upd[2] : '0;
        out_next.hits_rb = tag4_reg.last ? count_upd[3] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SIDE_COUNT; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            v4_reg        <= s1_valid;
            out_valid_reg <= v4_reg;
            if (v4_reg)
            begin
                for (int i = 0; i < SIDE_COUNT; i++)
                begin
                    count_reg[i] <= count_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag4_reg  <= s1_tag;
            s1_4_reg  <= s1_value;
            prod4_reg <= prod4_next;
            out_reg   <= out_next;
            last_reg  <= tag4_reg.last;
            sat_reg   <= tag4_reg.sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_word     = out_reg;
    assign out_last     = last_reg;
    assign out_sat      = sat_reg;
    assign counts_clear = adv && v4_reg && tag4_reg.last;

endmodule

// File: tb/strip_detector_calibration_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strip detector calibration testbench
// Loads strip coefficients, streams samples through the two calibration
// stages under random stalls on both sides and one long output hold-off,
// and compares every output word with a cycle-free model of the block.
// Register settings change between phases, only with the pipeline drained.
// ----------------------------------------------------------------------------
module strip_detector_calibration_test;
    import sdc_pkg::*;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [1:0] SIDE_LF = 2'd0;
    localparam logic [1:0] SIDE_LB = 2'd1;
    localparam logic [1:0] SIDE_RF = 2'd2;
    localparam logic [1:0] SIDE_RB = 2'd3;

    localparam int PHASE_WORDS  = 360;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        logic    action;
        sdc_in_t data;
        logic    last;
    } strip_word_t;

    typedef struct packed {
        sdc_out_t data;
        logic     sat;
        logic     last;
    } strip_result_t;

    typedef struct {
        strip_word_t   w;
        bit            typed;
        strip_result_t want;
    } directed_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         m_axis_tuser;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [23:0]  cfg_data;

    longint        strip_gain [128];
    longint        strip_offset [128];
    bit            strip_loaded [128];
    logic [5:0]    side_hits [4];
    longint        hit_level;
    longint        half_gain [2];
    longint        half_offset [2];
    strip_result_t calibrated_queue [$];
    directed_row_t strip_plan [$];
    int            mismatch_count;
    bit            steady;
    bit            hold_req;
    int            event_left;
    bit            long_event;
    logic [1:0]    focus_side;
    logic [6:0]    last_addr;

    strip_detector_calibration DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint round_shift(longint x, int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clamp32(longint x);
        longint r;
        r = x;
        if (x > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (x < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    function automatic strip_result_t calibrate_strip(strip_word_t w);
        strip_result_t r;
        logic [6:0]    addr;
        longint        raw;
        longint        s1;
        longint        c;
        bit            half;
        addr = {w.data.strip_side, w.data.strip_index};
        raw = longint'(w.data.raw_adc);
        half = w.data.strip_side[1];
        r = '0;
        r.sat = (w.data.raw_adc > ADC_LIMIT);
        r.last = w.last;
        r.data.side_out = w.data.strip_side;
        r.data.index_out = w.data.strip_index;
        if (r.sat)
        begin
            r.data.raw_echo = RAW_SENTINEL;
            s1 = VAL_SENTINEL;
            c = VAL_SENTINEL;
        end
        else
        begin
            r.data.raw_echo = 15'(w.data.raw_adc);
            s1 = clamp32(round_shift(strip_gain[addr] * raw, 6) + strip_offset[addr]);
            c = clamp32(round_shift(half_gain[half] * s1, 16) + half_offset[half]);
        end
        r.data.stage_one_value = 32'(s1);
        r.data.calibrated_value = 32'(c);
        if (c > hit_level * 256 && side_hits[w.data.strip_side] != COUNT_MAX)
            side_hits[w.data.strip_side]++;
        if (w.last)
        begin
            r.data.hits_lf = side_hits[SIDE_LF];
            r.data.hits_lb = side_hits[SIDE_LB];
            r.data.hits_rf = side_hits[SIDE_RF];
            r.data.hits_rb = side_hits[SIDE_RB];
            foreach (side_hits[i])
                side_hits[i] = '0;
        end
        return r;
    endfunction

    function automatic logic [23:0] pick_coef(int bits);
        logic [23:0] v;
        v = 24'($urandom);
        case ($urandom_range(7))
            0: v = 24'((1 << (bits - 1)) - 1);
            1: v = 24'(-(1 << (bits - 1)));
            2: v = '0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic check_field(string what, longint want, longint got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic send_strip(strip_word_t w);
        logic [6:0] addr;
        addr = {w.data.strip_side, w.data.strip_index};
        while (!steady && $urandom_range(99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= 64'(w.data);
        s_axis_tuser <= w.action;
        s_axis_tlast <= w.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (w.action == ACT_LOAD)
        begin
            strip_gain[addr] = $signed(w.data.coef_gain);
            strip_offset[addr] = $signed(w.data.coef_offset);
            strip_loaded[addr] = 1'b1;
        end
        else
            calibrated_queue.push_back(calibrate_strip(w));
    endtask

    task automatic plan(logic action, logic [1:0] side, logic [4:0] idx, logic [12:0] raw,
                        int gain, int offset, logic last);
        directed_row_t row;
        row.w.action = action;
        row.w.data.strip_side = side;
        row.w.data.strip_index = idx;
        row.w.data.raw_adc = raw;
        row.w.data.coef_gain = 18'(gain);
        row.w.data.coef_offset = 24'(offset);
        row.w.last = last;
        row.typed = 1'b0;
        row.want = '0;
        strip_plan.push_back(row);
    endtask

    task automatic plan_typed(logic [1:0] side, logic [4:0] idx, logic [12:0] raw, logic last,
                              int echo, int s1, int cal, logic sat,
                              int lf, int lb, int rf, int rb);
        strip_result_t want;
        want.data.side_out = side;
        want.data.index_out = idx;
        want.data.raw_echo = 15'(echo);
        want.data.stage_one_value = 32'(s1);
        want.data.calibrated_value = 32'(cal);
        want.data.hits_lf = 6'(lf);
        want.data.hits_lb = 6'(lb);
        want.data.hits_rf = 6'(rf);
        want.data.hits_rb = 6'(rb);
        want.sat = sat;
        want.last = last;
        plan(ACT_SAMPLE, side, idx, raw, 0, 0, last);
        strip_plan[strip_plan.size() - 1].typed = 1'b1;
        strip_plan[strip_plan.size() - 1].want = want;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (calibrated_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_HIT_THRESHOLD:    hit_level = $signed(value[THR_W-1:0]);
            REG_CAL_GAIN_LEFT:    half_gain[0] = $signed(value[CAL_GAIN_W-1:0]);
            REG_CAL_OFFSET_LEFT:  half_offset[0] = $signed(value[OFFSET_W-1:0]);
            REG_CAL_GAIN_RIGHT:   half_gain[1] = $signed(value[CAL_GAIN_W-1:0]);
            REG_CAL_OFFSET_RIGHT: half_offset[1] = $signed(value[OFFSET_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic apply_settings(int thr, int gain_l, int off_l, int gain_r, int off_r);
        write_reg(REG_HIT_THRESHOLD, 24'(thr));
        write_reg(REG_CAL_GAIN_LEFT, 24'(gain_l));
        write_reg(REG_CAL_OFFSET_LEFT, 24'(off_l));
        write_reg(REG_CAL_GAIN_RIGHT, 24'(gain_r));
        write_reg(REG_CAL_OFFSET_RIGHT, 24'(off_r));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(int count);
        strip_word_t w;
        logic [6:0]  addr;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            addr = ($urandom_range(99) < 20) ? last_addr : 7'($urandom);
            if (long_event && $urandom_range(9) != 0)
                addr[6:5] = focus_side;
            pick = $urandom_range(99);
            w.data.strip_side = addr[6:5];
            w.data.strip_index = addr[4:0];
            w.data.coef_gain = 18'(pick_coef(GAIN_W));
            w.data.coef_offset = pick_coef(OFFSET_W);
            if (pick < 8)
                w.data.raw_adc = 13'(4097 + $urandom_range(4094));
            else if (pick < 10)
                w.data.raw_adc = ADC_LIMIT;
            else if (pick < 12)
                w.data.raw_adc = ADC_LIMIT + 13'd1;
            else if (pick < 14)
                w.data.raw_adc = '0;
            else
                w.data.raw_adc = 13'($urandom_range(4096));
            if (!strip_loaded[addr] || $urandom_range(99) < 25)
            begin
                w.action = ACT_LOAD;
                w.last = 1'($urandom);
            end
            else
            begin
                w.action = ACT_SAMPLE;
                if (event_left == 0)
                begin
                    long_event = ($urandom_range(9) == 0);
                    event_left = long_event ? 80 + $urandom_range(40) : 1 + $urandom_range(11);
                    focus_side = 2'($urandom);
                end
                w.last = (event_left == 1);
                event_left--;
            end
            last_addr = addr;
            send_strip(w);
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        strip_result_t got;
        strip_result_t want;
        int            stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
            begin
                got.data = m_axis_tdata[$bits(sdc_out_t)-1:0];
                got.sat = m_axis_tuser;
                got.last = m_axis_tlast;
                if (calibrated_queue.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected word, side %0d index %0d value %0d",
                             $time, got.data.side_out, got.data.index_out,
                             got.data.calibrated_value);
                end
                else
                begin
                    want = calibrated_queue.pop_front();
                    check_field("side_out", want.data.side_out, got.data.side_out);
                    check_field("index_out", want.data.index_out, got.data.index_out);
                    check_field("raw_echo", want.data.raw_echo, got.data.raw_echo);
                    check_field("stage_one_value", want.data.stage_one_value,
                                got.data.stage_one_value);
                    check_field("calibrated_value", want.data.calibrated_value,
                                got.data.calibrated_value);
                    check_field("adc_saturated", want.sat, got.sat);
                    check_field("event_end", want.last, got.last);
                    check_field("hits_lf", want.data.hits_lf, got.data.hits_lf);
                    check_field("hits_lb", want.data.hits_lb, got.data.hits_lb);
                    check_field("hits_rf", want.data.hits_rf, got.data.hits_rf);
                    check_field("hits_rb", want.data.hits_rb, got.data.hits_rb);
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (stall = 0; stall < STALL_CYCLES; stall++)
                    @(posedge clk);
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= 21);
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = ACT_LOAD;
        cfg_wr_en = 1'b0;
        cfg_index = REG_HIT_THRESHOLD;
        cfg_data = '0;
        mismatch_count = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        event_left = 0;
        long_event = 1'b0;
        focus_side = SIDE_LF;
        last_addr = '0;
        foreach (side_hits[i])
            side_hits[i] = '0;
        hit_level = RST_HIT_THRESHOLD;
        half_gain[0] = RST_CAL_GAIN_LEFT;
        half_offset[0] = RST_CAL_OFFSET_LEFT;
        half_gain[1] = RST_CAL_GAIN_RIGHT;
        half_offset[1] = RST_CAL_OFFSET_RIGHT;

        plan(ACT_LOAD, SIDE_LF, 5'd0, 13'd0, 16384, 0, 1'b0);
        plan(ACT_LOAD, SIDE_RB, 5'd31, 13'd0, -131072, -8388608, 1'b0);
        plan(ACT_LOAD, SIDE_LB, 5'd5, 13'd8191, 131071, 8388607, 1'b1);
        plan(ACT_LOAD, SIDE_RF, 5'd17, 13'd0, 0, 0, 1'b0);
        plan_typed(SIDE_LF, 5'd0, 13'd0, 1'b0, 0, 0, -390206, 1'b0, 0, 0, 0, 0);
        plan_typed(SIDE_LF, 5'd0, 13'd4097, 1'b0, -9999, -2559744, -2559744, 1'b1,
                   0, 0, 0, 0);
        plan(ACT_SAMPLE, SIDE_RB, 5'd31, 13'd4096, 0, 0, 1'b0);
        plan(ACT_SAMPLE, SIDE_LB, 5'd5, 13'd4096, 0, 0, 1'b0);
        plan_typed(SIDE_RF, 5'd17, 13'd8191, 1'b1, -9999, -2559744, -2559744, 1'b1,
                   0, 1, 0, 0);
        plan_typed(SIDE_LF, 5'd0, 13'd0, 1'b1, 0, 0, -390206, 1'b0, 0, 0, 0, 0);
        plan(ACT_LOAD, SIDE_RF, 5'd17, 13'd0, 16384, 256, 1'b0);
        plan(ACT_SAMPLE, SIDE_RF, 5'd17, 13'd100, 0, 0, 1'b0);
        plan(ACT_LOAD, SIDE_RF, 5'd17, 13'd0, -16384, -256, 1'b1);
        plan(ACT_LOAD, SIDE_RF, 5'd17, 13'd0, 5000, 1000, 1'b0);
        plan(ACT_SAMPLE, SIDE_RF, 5'd17, 13'd4095, 0, 0, 1'b0);
        plan(ACT_LOAD, SIDE_LB, 5'd31, 13'd0, 65535, -1, 1'b0);
        plan(ACT_SAMPLE, SIDE_LB, 5'd31, 13'd8190, 0, 0, 1'b0);
        plan(ACT_SAMPLE, SIDE_LB, 5'd31, 13'd1, 0, 0, 1'b0);
        plan(ACT_SAMPLE, SIDE_RB, 5'd31, 13'd1, 0, 0, 1'b1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (strip_plan[i])
        begin
            send_strip(strip_plan[i].w);
            if (strip_plan[i].typed)
                calibrated_queue[calibrated_queue.size() - 1] = strip_plan[i].want;
        end
        run_random(PHASE_WORDS);

        settle();
        apply_settings(-32768, 0, 8388607, -524288, -8388608);
        run_random(PHASE_WORDS);

        settle();
        apply_settings(32767, 524287, -8388608, 524287, 8388607);
        hold_req = 1'b1;
        run_random(PHASE_WORDS);

        settle();
        apply_settings(int'($urandom_range(65535)) - 32768,
                       int'($urandom_range(1048575)) - 524288,
                       int'($urandom_range(16777215)) - 8388608,
                       int'($urandom_range(1048575)) - 524288,
                       int'($urandom_range(16777215)) - 8388608);
        run_random(PHASE_WORDS);

        settle();
        apply_settings(0, 65536, 0, 65536, 0);
        steady = 1'b1;
        run_random(PHASE_WORDS / 2);
        steady = 1'b0;
        run_random(PHASE_WORDS / 2);

        // drain, then hold a little longer to catch stray words
        s_axis_tvalid <= 1'b0;
        for (n = 0; n < 20000 && calibrated_queue.size() != 0; n++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (calibrated_queue.size() != 0)
        begin
            mismatch_count++;
            $display("%0t ns: %0d calibrated words expected, 0 received",
                     $time, calibrated_queue.size());
        end
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/sdc_pkg.sv
design/sdc_ram.sv
design/sdc_coef_stage.sv
design/sdc_gain_stage.sv
design/strip_detector_calibration.sv
tb/strip_detector_calibration_test.sv
